/* sv/tspl_pkg.sv */
`default_nettype none

package tspl_pkg;

  localparam int NumSegments = 21;
  localparam int NumEdges    = NumSegments + 1;
  localparam int NumStages   = 6;

  localparam int CalWidth    = 13;
  localparam int SampleWidth = 12;
  localparam int TempWidth   = 23;
  localparam int SegWidth    = 5;

  // Millivolts carry 11 fraction bits: sample * calibration is Q.11.
  localparam int FracBits    = 11;
  localparam int MvWidth     = SampleWidth + CalWidth;
  localparam int EdgeWidth   = 11;
  localparam int SlopeWidth  = 19;
  localparam int IcptWidth   = 28;
  localparam int ProdWidth   = SlopeWidth + MvWidth + 1;
  localparam int NumWidth    = ProdWidth + 1;
  localparam int MagWidth    = 32;

  localparam logic [CalWidth-1:0] CalReset = CalWidth'(2048);

  // Division by 1000 of a 32-bit value: (x * DivMagic) >> DivShift is exact.
  localparam logic [28:0] DivMagic = 29'd274877907;
  localparam int          DivShift = 38;
  localparam int          QuoWidth = TempWidth;

  localparam logic [SegWidth-1:0] LastSeg = SegWidth'(NumSegments - 1);

  typedef logic [SegWidth-1:0] seg_idx_t;

  // Interval edges in whole millivolts, falling.
  function automatic logic [EdgeWidth-1:0] seg_edge_mv(input seg_idx_t idx);
    logic [EdgeWidth-1:0] mv;
    case (idx)
      5'd0:    mv = 11'd1375;
      5'd1:    mv = 11'd1350;
      5'd2:    mv = 11'd1301;
      5'd3:    mv = 11'd1250;
      5'd4:    mv = 11'd1200;
      5'd5:    mv = 11'd1149;
      5'd6:    mv = 11'd1098;
      5'd7:    mv = 11'd1047;
      5'd8:    mv = 11'd995;
      5'd9:    mv = 11'd943;
      5'd10:   mv = 11'd891;
      5'd11:   mv = 11'd839;
      5'd12:   mv = 11'd786;
      5'd13:   mv = 11'd734;
      5'd14:   mv = 11'd681;
      5'd15:   mv = 11'd627;
      5'd16:   mv = 11'd574;
      5'd17:   mv = 11'd521;
      5'd18:   mv = 11'd467;
      5'd19:   mv = 11'd413;
      5'd20:   mv = 11'd358;
      default: mv = 11'd303;
    endcase
    return mv;
  endfunction

  function automatic logic signed [SlopeWidth-1:0] seg_slope(input seg_idx_t idx);
    logic signed [SlopeWidth-1:0] s;
    case (idx)
      5'd0:    s = -19'sd201792;
      5'd1:    s = -19'sd200610;
      5'd2:    s = -19'sd199223;
      5'd3:    s = -19'sd197965;
      5'd4:    s = -19'sd196796;
      5'd5:    s = -19'sd195760;
      5'd6:    s = -19'sd194780;
      5'd7:    s = -19'sd193810;
      5'd8:    s = -19'sd192965;
      5'd9:    s = -19'sd192127;
      5'd10:   s = -19'sd191219;
      5'd11:   s = -19'sd190396;
      5'd12:   s = -19'sd189566;
      5'd13:   s = -19'sd188843;
      5'd14:   s = -19'sd188097;
      5'd15:   s = -19'sd187361;
      5'd16:   s = -19'sd186686;
      5'd17:   s = -19'sd185905;
      5'd18:   s = -19'sd185113;
      5'd19:   s = -19'sd183234;
      default: s = -19'sd180574;
    endcase
    return s;
  endfunction

  function automatic logic [IcptWidth-1:0] seg_intercept(input seg_idx_t idx);
    logic [IcptWidth-1:0] c;
    case (idx)
      5'd0:    c = 28'd222508064;
      5'd1:    c = 28'd220911776;
      5'd2:    c = 28'd219108080;
      5'd3:    c = 28'd217534944;
      5'd4:    c = 28'd216132576;
      5'd5:    c = 28'd214941760;
      5'd6:    c = 28'd213865792;
      5'd7:    c = 28'd212850352;
      5'd8:    c = 28'd212009344;
      5'd9:    c = 28'd211219040;
      5'd10:   c = 28'd210410352;
      5'd11:   c = 28'd209720128;
      5'd12:   c = 28'd209067344;
      5'd13:   c = 28'd208536848;
      5'd14:   c = 28'd208029120;
      5'd15:   c = 28'd207566944;
      5'd16:   c = 28'd207179360;
      5'd17:   c = 28'd206772880;
      5'd18:   c = 28'd206403440;
      5'd19:   c = 28'd205627856;
      default: c = 28'd204675072;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/temp_sensor_piecewise_linearizer_top.sv */
// A request accepted at a clock edge is loaded into the first of six stages (one
// multiply, compare, table multiply, add, divide-by-1000, negate) and passes through
// them in that order to the outputs.
// Throughput: one request per cycle while out_stall_i is low; each of the six stages
// holds a valid bit and only stalls when it is full and the stage after it is stalled.
// Reset clears all stage valid bits and sets the calibration register to 2048.
`default_nettype none

module temp_sensor_piecewise_linearizer_top (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [tspl_pkg::CalWidth-1:0]     cfg_data_i,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire [tspl_pkg::SampleWidth-1:0]  adc_sample_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic signed [tspl_pkg::TempWidth-1:0] temp_millideg_o,
  output logic [tspl_pkg::SegWidth-1:0]    segment_index_o,
  output logic                             out_of_range_o
);
  import tspl_pkg::*;

  logic [CalWidth-1:0]  cal_q;
  logic [NumStages-1:0] v_q, v_d;
  logic [NumStages:0]   rdy;

  // Stage payloads.
  logic [MvWidth-1:0]   s1_mv_q, s2_mv_q;
  logic [MvWidth-1:0]   s1_mv_d;
  seg_idx_t             s2_seg_q, s3_seg_q, s4_seg_q, s5_seg_q;
  seg_idx_t             s2_seg_d;
  logic                 s2_oor_q, s3_oor_q, s4_oor_q, s5_oor_q;
  logic                 s2_oor_d;
  logic signed [ProdWidth-1:0] s3_prod_q, s3_prod_d;
  logic [IcptWidth-1:0] s3_icpt_q;
  logic [MagWidth-1:0]  s4_mag_q;
  logic                 s4_neg_q, s5_neg_q;
  logic signed [NumWidth-1:0] s4_num;
  logic [NumWidth-1:0]  s4_abs;
  logic [QuoWidth-1:0]  s5_quo_q;
  logic [MagWidth+29-1:0] s5_prod;
  logic signed [TempWidth-1:0] s6_temp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= CalReset;
    end else if (cfg_we_i) begin
      cal_q <= cfg_data_i;
    end
  end

  // A stage can take a new request if it is empty or its content moves on.
  always_comb begin
    rdy[NumStages] = !out_stall_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    v_d = v_q;
    if (rdy[0]) begin
      v_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (rdy[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o = !rdy[0];

  // Stage 1: millivolts in Q.11.
  assign s1_mv_d = MvWidth'(adc_sample_i) * MvWidth'(cal_q);

  // Stage 2: the edges fall, so the passed compares form a prefix and their
  // count is the segment index.
  always_comb begin
    logic [MvWidth-1:0] edge_q11;
    s2_seg_d = '0;
    for (int k = 1; k < NumSegments; k++) begin
      edge_q11 = MvWidth'(seg_edge_mv(SegWidth'(k))) << FracBits;
      s2_seg_d = s2_seg_d + SegWidth'(s1_mv_q <= edge_q11);
    end
    s2_oor_d = (s1_mv_q > (MvWidth'(seg_edge_mv('0)) << FracBits)) ||
               (s1_mv_q <= (MvWidth'(seg_edge_mv(SegWidth'(NumSegments))) << FracBits));
  end

  // Stage 3: slope times voltage.
  always_comb begin
    logic signed [MvWidth:0] mv_s;
    mv_s      = $signed({1'b0, s2_mv_q});
    s3_prod_d = ProdWidth'(seg_slope(s2_seg_q)) * ProdWidth'(mv_s);
  end

  // Stage 4: add the scaled intercept, take the magnitude and drop 11 bits.
  assign s4_num = NumWidth'(s3_prod_q) +
                  $signed({{(NumWidth-IcptWidth-FracBits){1'b0}}, s3_icpt_q,
                           {FracBits{1'b0}}});
  assign s4_abs = s4_num[NumWidth-1] ? NumWidth'(-s4_num) : NumWidth'(s4_num);

  // Stage 5: divide the magnitude by 1000.
  assign s5_prod = (MagWidth+29)'(s4_mag_q) * (MagWidth+29)'(DivMagic);

  // Stage 6: restore the sign, which truncates toward zero.
  assign s6_temp_d = s5_neg_q ? TempWidth'(-$signed(s5_quo_q)) : $signed(s5_quo_q);

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s1_mv_q <= s1_mv_d;
    end
    if (rdy[1]) begin
      s2_mv_q  <= s1_mv_q;
      s2_seg_q <= s2_seg_d;
      s2_oor_q <= s2_oor_d;
    end
    if (rdy[2]) begin
      s3_prod_q <= s3_prod_d;
      s3_icpt_q <= seg_intercept(s2_seg_q);
      s3_seg_q  <= s2_seg_q;
      s3_oor_q  <= s2_oor_q;
    end
    if (rdy[3]) begin
      s4_mag_q <= s4_abs[FracBits +: MagWidth];
      s4_neg_q <= s4_num[NumWidth-1];
      s4_seg_q <= s3_seg_q;
      s4_oor_q <= s3_oor_q;
    end
    if (rdy[4]) begin
      s5_quo_q <= s5_prod[DivShift +: QuoWidth];
      s5_neg_q <= s4_neg_q;
      s5_seg_q <= s4_seg_q;
      s5_oor_q <= s4_oor_q;
    end
    if (rdy[5]) begin
      temp_millideg_o <= s6_temp_d;
      segment_index_o <= s5_seg_q;
      out_of_range_o  <= s5_oor_q;
    end
  end

  assign out_valid_o = v_q[NumStages-1];

  a_seg_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> segment_index_o <= LastSeg)
    else $error("segment index beyond table");

  a_oor_end_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> segment_index_o == '0 || segment_index_o == LastSeg)
    else $error("extrapolation not on an end segment");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&v_q) && out_stall_i |-> in_stall_o)
    else $error("full stalled pipeline takes a request");

  a_empty_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[0] |-> !in_stall_o)
    else $error("empty first stage stalls input");

endmodule

`default_nettype wire
